[rtl/c8ic_pkg.sv]
// ----------------------------------------------------------------------------
// c8ic_pkg
// Types and fixed codes shared by the instruction core modules.
// ----------------------------------------------------------------------------
package c8ic_pkg;

	// Command codes of an input transaction.
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_STEP  = 2'd1;
	localparam logic [1:0] CMD_PIXEL = 2'd2;

	// Opcode groups (upper nibble).
	localparam logic [3:0] GRP_SYS     = 4'h0;
	localparam logic [3:0] GRP_JP      = 4'h1;
	localparam logic [3:0] GRP_CALL    = 4'h2;
	localparam logic [3:0] GRP_SE_IMM  = 4'h3;
	localparam logic [3:0] GRP_SNE_IMM = 4'h4;
	localparam logic [3:0] GRP_SE_REG  = 4'h5;
	localparam logic [3:0] GRP_LD_IMM  = 4'h6;
	localparam logic [3:0] GRP_ADD_IMM = 4'h7;
	localparam logic [3:0] GRP_ALU     = 4'h8;
	localparam logic [3:0] GRP_SNE_REG = 4'h9;
	localparam logic [3:0] GRP_LD_I    = 4'hA;
	localparam logic [3:0] GRP_JP_V0   = 4'hB;
	localparam logic [3:0] GRP_DRAW    = 4'hD;

	// Whole opcodes of the system group.
	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;

	// Low nibble of the register ALU group.
	localparam logic [3:0] SUB_MOV  = 4'h0;
	localparam logic [3:0] SUB_OR   = 4'h1;
	localparam logic [3:0] SUB_AND  = 4'h2;
	localparam logic [3:0] SUB_XOR  = 4'h3;
	localparam logic [3:0] SUB_ADD  = 4'h4;
	localparam logic [3:0] SUB_SUB  = 4'h5;
	localparam logic [3:0] SUB_SHR  = 4'h6;
	localparam logic [3:0] SUB_SUBN = 4'h7;
	localparam logic [3:0] SUB_SHL  = 4'hE;

	localparam logic [11:0] PC_RESET = 12'h200;
	localparam logic [3:0]  VF_IDX   = 4'hF;

	typedef enum logic [3:0] {
		ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL
	} alu_op_t;

	typedef struct packed {
		alu_op_t    op;
		logic [7:0] a;
		logic [7:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [7:0] res;
		logic       flag;
		logic       eq;
	} alu_rsp_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [11:0] addr;
		logic [7:0]  wdata;
	} c8ic_req_t;

	typedef struct packed {
		logic [11:0] pc_after;
		logic [15:0] opcode_seen;
		logic        status;
		logic [7:0]  flag_value;
		logic        screen_changed;
		logic        pixel;
	} c8ic_rsp_t;

endpackage

[rtl/chip8_instruction_core_unit.sv]
// ----------------------------------------------------------------------------
// chip8_instruction_core_unit
// Small CHIP-8 machine run one transaction at a time by a sequencer.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Command write
// stores a program byte, command step fetches and executes one instruction,
// command pixel returns one frame-buffer bit. Every transaction yields one
// result, shown on rsp for exactly one cycle while done is high; the receiver
// cannot hold it off, and busy stays high until that cycle has passed.
// A step fetches with two reads of the program memory's single read port,
// then reads Vx and Vy through the one register-file read port and makes
// one pass through the shared ALU, and a second pass when the ALU also
// writes VF. Clear writes one frame-buffer word a cycle. Draw first reduces
// Vx and Vy into the screen by repeated subtraction, then reads each sprite
// row and does a read-modify-write of the frame buffer for each set bit.
// After reset a clearing pass zeroes program memory and the frame buffer,
// with busy high throughout.
// ----------------------------------------------------------------------------
module chip8_instruction_core_unit #(
	parameter int MEMORY_BYTES = 4096,
	parameter int SCREEN_W     = 64,
	parameter int SCREEN_H     = 32,
	parameter int STACK_DEPTH  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  c8ic_pkg::c8ic_req_t req,
	output logic                busy,
	output logic                done,
	output c8ic_pkg::c8ic_rsp_t rsp
);
	import c8ic_pkg::*;

	localparam int PIXELS = SCREEN_W * SCREEN_H;
	localparam int MAW    = $clog2(MEMORY_BYTES);
	localparam int PAW    = $clog2(PIXELS);
	localparam int MAXD   = (MEMORY_BYTES > PIXELS) ? MEMORY_BYTES : PIXELS;
	localparam int CW     = $clog2(MAXD);
	localparam int SPW    = $clog2(STACK_DEPTH);

	typedef enum logic [4:0] {
		ST_CLR, ST_IDLE, ST_FHI, ST_FLO, ST_FCAP, ST_RDX, ST_RDY, ST_EXEC, ST_WRES,
		ST_CLS, ST_DMOD, ST_DROW, ST_DBYTE, ST_DCOL, ST_DPW, ST_DADV, ST_PIX, ST_DONE
	} state_t;

	// Program addresses wrap at the memory size; inputs below five sizes are reduced fully.
	function automatic logic [MAW-1:0] mem_wrap(input logic [12:0] a);
		logic [12:0] t;
		t = a;
		for (int k = 0; k < 4; k++) begin
			if (t >= 13'(MEMORY_BYTES)) begin
				t = t - 13'(MEMORY_BYTES);
			end
		end
		return t[MAW-1:0];
	endfunction

	state_t       state_q;
	logic [11:0]  pc_q;
	logic [11:0]  i_q;
	logic [SPW-1:0] sp_q;
	logic [11:0]  stack_q [STACK_DEPTH];
	logic [7:0]   v_q [16];
	logic [15:0]  op_q;
	logic         status_q;
	logic         changed_q;
	logic         pix_q;
	logic         inrange_q;
	logic [7:0]   a_q;
	logic [7:0]   b_q;
	logic [CW-1:0] cnt_q;
	logic [7:0]   px_q;
	logic [7:0]   py_q;
	logic [7:0]   cx_q;
	logic [PAW-1:0] base_q;
	logic [3:0]   r_q;
	logic [2:0]   c_q;
	logic [7:0]   bits_q;

	logic [3:0]   opc, x, y, n;
	logic [7:0]   kk;
	logic [11:0]  nnn;
	logic [3:0]   rd_idx;
	logic [7:0]   rd_val;
	logic [SPW-1:0] sp_dec;
	logic [SPW-1:0] sp_inc;
	logic         flag_op;
	logic [PAW-1:0] pix_addr;
	alu_req_t     alu_req;
	alu_rsp_t     alu_rsp;

	logic           mem_we;
	logic [MAW-1:0] mem_waddr;
	logic [7:0]     mem_wdata;
	logic [MAW-1:0] mem_raddr;
	logic [7:0]     mem_rdata;
	logic           fb_we;
	logic [PAW-1:0] fb_waddr;
	logic           fb_wdata;
	logic [PAW-1:0] fb_raddr;
	logic           fb_rdata;
	logic           accept;

	assign accept = start && (state_q == ST_IDLE);

	// Instruction fields.
	assign opc = op_q[15:12];
	assign x   = op_q[11:8];
	assign y   = op_q[7:4];
	assign n   = op_q[3:0];
	assign kk  = op_q[7:0];
	assign nnn = op_q[11:0];

	assign sp_dec = (sp_q == '0) ? SPW'(STACK_DEPTH - 1) : sp_q - 1'b1;
	assign sp_inc = (sp_q == SPW'(STACK_DEPTH - 1)) ? '0 : sp_q + 1'b1;

	assign flag_op = (n == SUB_ADD) || (n == SUB_SUB) || (n == SUB_SHR) ||
			(n == SUB_SUBN) || (n == SUB_SHL);

	assign pix_addr = base_q + PAW'(cx_q);

	// Register-file read port: Vx (or V0 for the offset jump), then Vy.
	assign rd_idx = (state_q == ST_RDX) ? ((opc == GRP_JP_V0) ? 4'h0 : x) : y;
	assign rd_val = v_q[rd_idx];

	// Shared ALU operand and operation select.
	always_comb begin
		alu_req.a  = a_q;
		alu_req.b  = ((opc == GRP_SE_IMM) || (opc == GRP_SNE_IMM) ||
				(opc == GRP_ADD_IMM)) ? kk : b_q;
		alu_req.op = ALU_ADD;
		if (opc == GRP_ALU) begin
			case (n)
				SUB_MOV:  alu_req.op = ALU_MOV;
				SUB_OR:   alu_req.op = ALU_OR;
				SUB_AND:  alu_req.op = ALU_AND;
				SUB_XOR:  alu_req.op = ALU_XOR;
				SUB_ADD:  alu_req.op = ALU_ADD;
				SUB_SUB:  alu_req.op = ALU_SUB;
				SUB_SHR:  alu_req.op = ALU_SHR;
				SUB_SUBN: alu_req.op = ALU_SUBN;
				SUB_SHL:  alu_req.op = ALU_SHL;
				default:  alu_req.op = ALU_MOV;
			endcase
		end
	end

	c8ic_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// Program memory port control.
	always_comb begin
		mem_we    = accept && (req.cmd == CMD_WRITE);
		mem_waddr = mem_wrap({1'b0, req.addr});
		mem_wdata = req.wdata;
		if (state_q == ST_CLR) begin
			mem_we    = ({1'b0, cnt_q} < (CW+1)'(MEMORY_BYTES));
			mem_waddr = cnt_q[MAW-1:0];
			mem_wdata = 8'h00;
		end
		case (state_q)
			ST_FHI:  mem_raddr = mem_wrap({1'b0, pc_q});
			ST_FLO:  mem_raddr = mem_wrap({1'b0, pc_q} + 13'd1);
			default: mem_raddr = mem_wrap({1'b0, i_q} + 13'(r_q));
		endcase
	end

	c8ic_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Frame buffer port control.
	always_comb begin
		fb_we    = 1'b0;
		fb_waddr = pix_addr;
		fb_wdata = 1'b0;
		case (state_q)
			ST_CLR: begin
				fb_we    = ({1'b0, cnt_q} < (CW+1)'(PIXELS));
				fb_waddr = cnt_q[PAW-1:0];
			end
			ST_CLS: begin
				fb_we    = 1'b1;
				fb_waddr = cnt_q[PAW-1:0];
			end
			ST_DPW: begin
				fb_we    = 1'b1;
				fb_wdata = ~fb_rdata;
			end
			default: begin
				fb_we = 1'b0;
			end
		endcase
		fb_raddr = (state_q == ST_IDLE) ? PAW'(req.addr) : pix_addr;
	end

	c8ic_ram #(.WIDTH(1), .DEPTH(PIXELS)) u_fb (
		.clk   (clk),
		.we    (fb_we),
		.waddr (fb_waddr),
		.wdata (fb_wdata),
		.raddr (fb_raddr),
		.rdata (fb_rdata)
	);

	// Sequencer with the machine state and the result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			pc_q      <= PC_RESET;
			i_q       <= '0;
			sp_q      <= '0;
			op_q      <= '0;
			status_q  <= 1'b0;
			changed_q <= 1'b0;
			pix_q     <= 1'b0;
			inrange_q <= 1'b0;
			cnt_q     <= '0;
			for (int k = 0; k < STACK_DEPTH; k++) begin
				stack_q[k] <= '0;
			end
			for (int k = 0; k < 16; k++) begin
				v_q[k] <= '0;
			end
		end else begin
			case (state_q)
				ST_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(MAXD - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						op_q      <= '0;
						status_q  <= 1'b0;
						changed_q <= 1'b0;
						pix_q     <= 1'b0;
						inrange_q <= (req.cmd == CMD_PIXEL) &&
								({2'b0, req.addr} < 14'(PIXELS));
						case (req.cmd)
							CMD_WRITE: state_q <= ST_DONE;
							CMD_STEP:  state_q <= ST_FHI;
							default:   state_q <= ST_PIX;
						endcase
					end
				end
				ST_FHI: begin
					state_q <= ST_FLO;
				end
				ST_FLO: begin
					op_q[15:8] <= mem_rdata;
					state_q    <= ST_FCAP;
				end
				ST_FCAP: begin
					op_q[7:0] <= mem_rdata;
					pc_q      <= pc_q + 12'd2;
					state_q   <= ST_RDX;
				end
				ST_RDX: begin
					a_q     <= rd_val;
					state_q <= ST_RDY;
				end
				ST_RDY: begin
					b_q     <= rd_val;
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
					case (opc)
						GRP_SYS: begin
							if (op_q == OP_CLS) begin
								changed_q <= 1'b1;
								cnt_q     <= '0;
								state_q   <= ST_CLS;
							end else if (op_q == OP_RET) begin
								sp_q <= sp_dec;
								pc_q <= stack_q[sp_dec];
							end else begin
								status_q <= 1'b1;
							end
						end
						GRP_JP: begin
							pc_q <= nnn;
						end
						GRP_CALL: begin
							stack_q[sp_q] <= pc_q;
							sp_q          <= sp_inc;
							pc_q          <= nnn;
						end
						GRP_SE_IMM, GRP_SE_REG: begin
							if (alu_rsp.eq) begin
								pc_q <= pc_q + 12'd2;
							end
						end
						GRP_SNE_IMM, GRP_SNE_REG: begin
							if (!alu_rsp.eq) begin
								pc_q <= pc_q + 12'd2;
							end
						end
						GRP_LD_IMM: begin
							v_q[x] <= kk;
						end
						GRP_ADD_IMM: begin
							v_q[x] <= alu_rsp.res;
						end
						GRP_ALU: begin
							if (flag_op) begin
								// Flag first; operands then see the new VF.
								v_q[VF_IDX] <= {7'b0, alu_rsp.flag};
								if (x == VF_IDX) begin
									a_q <= {7'b0, alu_rsp.flag};
								end
								if (y == VF_IDX) begin
									b_q <= {7'b0, alu_rsp.flag};
								end
								state_q <= ST_WRES;
							end else if (n[3:2] == 2'b00) begin
								v_q[x] <= alu_rsp.res;
							end else begin
								status_q <= 1'b1;
							end
						end
						GRP_LD_I: begin
							i_q <= nnn;
						end
						GRP_JP_V0: begin
							pc_q <= nnn + {4'b0, a_q};
						end
						GRP_DRAW: begin
							changed_q   <= 1'b1;
							v_q[VF_IDX] <= 8'h00;
							px_q        <= a_q;
							py_q        <= b_q;
							r_q         <= '0;
							state_q     <= ST_DMOD;
						end
						default: begin
							status_q <= 1'b1;
						end
					endcase
				end
				ST_WRES: begin
					v_q[x]  <= alu_rsp.res;
					state_q <= ST_DONE;
				end
				ST_CLS: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(PIXELS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				// Reduce the sprite origin into the screen by repeated subtraction.
				ST_DMOD: begin
					if (px_q >= 8'(SCREEN_W)) begin
						px_q <= px_q - 8'(SCREEN_W);
					end
					if (py_q >= 8'(SCREEN_H)) begin
						py_q <= py_q - 8'(SCREEN_H);
					end
					if ((px_q < 8'(SCREEN_W)) && (py_q < 8'(SCREEN_H))) begin
						base_q  <= PAW'(py_q * SCREEN_W);
						state_q <= ST_DROW;
					end
				end
				ST_DROW: begin
					state_q <= (r_q == n) ? ST_DONE : ST_DBYTE;
				end
				ST_DBYTE: begin
					bits_q  <= mem_rdata;
					c_q     <= '0;
					cx_q    <= px_q;
					state_q <= ST_DCOL;
				end
				ST_DCOL: begin
					state_q <= bits_q[7] ? ST_DPW : ST_DADV;
				end
				ST_DPW: begin
					if (fb_rdata) begin
						v_q[VF_IDX] <= 8'h01;
					end
					state_q <= ST_DADV;
				end
				// Step to the next column, or the next row at the end of a byte.
				ST_DADV: begin
					bits_q <= {bits_q[6:0], 1'b0};
					if (c_q == 3'd7) begin
						r_q <= r_q + 1'b1;
						if (py_q == 8'(SCREEN_H - 1)) begin
							py_q   <= '0;
							base_q <= '0;
						end else begin
							py_q   <= py_q + 1'b1;
							base_q <= base_q + PAW'(SCREEN_W);
						end
						state_q <= ST_DROW;
					end else begin
						c_q  <= c_q + 1'b1;
						cx_q <= (cx_q == 8'(SCREEN_W - 1)) ? 8'h00 : cx_q + 1'b1;
						state_q <= ST_DCOL;
					end
				end
				ST_PIX: begin
					pix_q   <= inrange_q & fb_rdata;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result transaction.
	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

	assign rsp.pc_after       = pc_q;
	assign rsp.opcode_seen    = op_q;
	assign rsp.status         = status_q;
	assign rsp.flag_value     = v_q[VF_IDX];
	assign rsp.screen_changed = changed_q;
	assign rsp.pixel          = pix_q;

endmodule

[rtl/c8ic_ram.sv]
// ----------------------------------------------------------------------------
// c8ic_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module c8ic_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/c8ic_alu.sv]
// ----------------------------------------------------------------------------
// c8ic_alu
// Shared 8-bit arithmetic unit: result, flag bit and equality compare.
// ----------------------------------------------------------------------------
module c8ic_alu (
	input  c8ic_pkg::alu_req_t req,
	output c8ic_pkg::alu_rsp_t rsp
);
	import c8ic_pkg::*;

	logic [8:0] sum;

	assign sum = {1'b0, req.a} + {1'b0, req.b};

	// Operation select; the flag follows the instruction set's rules.
	always_comb begin
		rsp.eq   = (req.a == req.b);
		rsp.res  = req.b;
		rsp.flag = 1'b0;
		case (req.op)
			ALU_MOV: begin
				rsp.res = req.b;
			end
			ALU_OR: begin
				rsp.res = req.a | req.b;
			end
			ALU_AND: begin
				rsp.res = req.a & req.b;
			end
			ALU_XOR: begin
				rsp.res = req.a ^ req.b;
			end
			ALU_ADD: begin
				rsp.res  = sum[7:0];
				rsp.flag = sum[8];
			end
			ALU_SUB: begin
				rsp.res  = req.a - req.b;
				rsp.flag = (req.a > req.b);
			end
			ALU_SHR: begin
				rsp.res  = {1'b0, req.a[7:1]};
				rsp.flag = req.a[0];
			end
			ALU_SUBN: begin
				rsp.res  = req.b - req.a;
				rsp.flag = (req.b > req.a);
			end
			ALU_SHL: begin
				rsp.res  = {req.a[6:0], 1'b0};
				rsp.flag = req.a[7];
			end
			default: begin
				rsp.res = req.b;
			end
		endcase
	end

endmodule
